[hdl/stt_pkg.sv]
`default_nettype none
package stt_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_SET   = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_RESET = 3'd3;
  localparam logic [2:0] KIND_PEEK  = 3'd4;
  localparam logic [2:0] KIND_SHIFT = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NONE_DUE  = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] deadline;
    logic [31:0] period;
    logic        rpt;
    logic        removing;
  } slot_t;
endpackage
`default_nettype wire

[hdl/stt_slot_ram.sv]
`default_nettype none
module stt_slot_ram
  import stt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire slot_t           wdata,
  input  wire logic [IdxW-1:0] raddr,
  output slot_t                rdata
);
  slot_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/software_timer_table.sv]
`default_nettype none
// software timer table: up to 16 timers kept in insertion order in one slot ram
// (one read port with a registered output, one write port). an item is taken
// when start is high and busy is low; each result appears for exactly one cycle
// with out_valid high, and the receiver cannot stall. set writes the next slot
// directly; clear, reset and peek search the table one slot per cycle; shift
// rewrites every slot; tick makes two passes over the table (purge marked
// timers, then fire and compact), emitting one fired timer per cycle. the single
// read port sets the rate.
module software_timer_table
  import stt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [47:0] in_now,
  input  wire logic [31:0] in_interval,
  input  wire logic        in_repeat_req,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [47:0] in_new_time,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [31:0]      out_result_id,
  output logic [47:0]      out_deadline,
  output logic [4:0]       out_occupancy,
  output logic             out_last
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // one pass: read i, act on data of i-1
  localparam logic [2:0] S_FIRE  = 3'd2;  // second tick pass
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_PEND  = 3'd4;  // tick: emit held result as last

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      kind_r;
  logic [47:0]     now_r, delta_r;
  logic [31:0]     ival_r, tid_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [31:0]     last_id_r, last_id_nxt;
  logic [CntW-1:0] rd_r, rd_nxt;          // next read index
  logic [CntW-1:0] wr_r, wr_nxt;          // compaction write index
  logic            vld_r, vld_nxt;        // ram data is for slot rd_r-1
  logic [IdxW-1:0] cur_r, cur_nxt;        // slot of ram data
  logic            fired_r, fired_nxt;
  logic            pend_r, pend_nxt;      // held fire result
  logic [31:0]     pend_id_r, pend_id_nxt;
  logic [CntW-1:0] drop_r, drop_nxt;      // one-shot timers this tick removes
  logic [CntW-1:0] occ_nxt;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t           wdata, rdata, upd;

  logic            ov_nxt, ol_nxt;
  logic [2:0]      os_nxt;
  logic [31:0]     oid_nxt;
  logic [47:0]     odl_nxt;

  stt_slot_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state_r != S_IDLE);
  assign raddr = rd_r[IdxW-1:0];

  always_comb begin
    logic [31:0] nid;
    logic        due, keep;
    state_nxt = state_r; count_nxt = count_r; last_id_nxt = last_id_r;
    rd_nxt = rd_r; wr_nxt = wr_r; vld_nxt = 1'b0; cur_nxt = cur_r;
    fired_nxt = fired_r; pend_nxt = pend_r; pend_id_nxt = pend_id_r;
    drop_nxt = drop_r;
    we = 1'b0; waddr = '0; wdata = rdata; upd = rdata;
    ov_nxt = 1'b0; ol_nxt = 1'b1; os_nxt = ST_OK; oid_nxt = '0; odl_nxt = '0;
    nid = last_id_r + 32'd1;
    if (nid == 32'd0) nid = 32'd1;
    due = (rdata.deadline <= now_r);
    keep = 1'b1;
    case (state_r)
      S_IDLE: begin
        rd_nxt = '0; wr_nxt = '0; fired_nxt = 1'b0; pend_nxt = 1'b0;
        drop_nxt = '0;
        if (start) begin
          state_nxt = S_SCAN;
          case (in_kind)
            KIND_SET: begin
              state_nxt = S_DONE;
              if (count_r >= CntW'(TableDepth)) begin
                os_nxt = ST_FULL;
              end else begin
                last_id_nxt = nid;
                we = 1'b1; waddr = count_r[IdxW-1:0];
                wdata.id = nid;
                wdata.deadline = in_now + 48'(in_interval);
                wdata.period = in_interval;
                wdata.rpt = in_repeat_req;
                wdata.removing = 1'b0;
                count_nxt = count_r + 1'b1;
                oid_nxt = nid;
              end
              ov_nxt = 1'b1;
            end
            KIND_CLEAR: begin
              if (in_timer_id[31]) begin
                state_nxt = S_DONE; ov_nxt = 1'b1; os_nxt = ST_INVALID;
              end
            end
            KIND_TICK, KIND_RESET, KIND_PEEK, KIND_SHIFT: ;
            default: begin
              state_nxt = S_DONE; ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN, S_FIRE: begin
        // issue next read
        if (rd_r < count_r) begin
          rd_nxt = rd_r + 1'b1; vld_nxt = 1'b1; cur_nxt = rd_r[IdxW-1:0];
        end
        if (vld_r) begin
          case (kind_r)
            KIND_CLEAR, KIND_RESET, KIND_PEEK: begin
              if (rdata.id == tid_r) begin
                vld_nxt = 1'b0; state_nxt = S_DONE; ov_nxt = 1'b1;
                if (kind_r == KIND_CLEAR) begin
                  we = 1'b1; waddr = cur_r; wdata.removing = 1'b1;
                end else if (kind_r == KIND_RESET) begin
                  we = 1'b1; waddr = cur_r; wdata.deadline = now_r + 48'(ival_r);
                end else begin
                  odl_nxt = rdata.deadline;
                end
              end
            end
            KIND_SHIFT: begin
              we = 1'b1; waddr = cur_r; wdata.deadline = rdata.deadline + delta_r;
            end
            default: begin
              if (state_r == S_SCAN) begin
                if (!rdata.removing) begin
                  we = 1'b1; waddr = wr_r[IdxW-1:0]; wr_nxt = wr_r + 1'b1;
                  // count ahead what the fire pass drops, for the occupancy
                  if (due && !rdata.rpt) drop_nxt = drop_r + 1'b1;
                end
              end else begin
                if (due) begin
                  if (!rdata.rpt) keep = 1'b0;
                  else if (rdata.period == 32'd0) upd.deadline = now_r;
                  else upd.deadline = rdata.deadline + 48'(rdata.period);
                  if (pend_r) begin
                    ov_nxt = 1'b1; ol_nxt = 1'b0; oid_nxt = pend_id_r;
                  end
                  pend_nxt = 1'b1; pend_id_nxt = rdata.id; fired_nxt = 1'b1;
                end
                if (keep) begin
                  we = 1'b1; waddr = wr_r[IdxW-1:0]; wr_nxt = wr_r + 1'b1;
                  wdata = upd;
                end
              end
            end
          endcase
        end
        // pass finished
        if (state_nxt == state_r && !vld_r && rd_r >= count_r) begin
          if (kind_r == KIND_TICK && state_r == S_SCAN) begin
            state_nxt = S_FIRE; count_nxt = wr_r; rd_nxt = '0; wr_nxt = '0;
          end else if (kind_r == KIND_TICK) begin
            count_nxt = wr_r; state_nxt = S_PEND;
          end else begin
            state_nxt = S_DONE; ov_nxt = 1'b1;
            if (kind_r != KIND_SHIFT) os_nxt = ST_NOT_FOUND;
          end
        end
      end
      S_PEND: begin
        state_nxt = S_DONE; ov_nxt = 1'b1;
        if (fired_r) oid_nxt = pend_id_r;
        else os_nxt = ST_NONE_DUE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // fire results carry the count left once the whole tick is done
    occ_nxt = (state_r == S_FIRE) ? count_r - drop_r : count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; last_id_r <= '0; vld_r <= 1'b0;
      out_valid <= 1'b0; fired_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; last_id_r <= last_id_nxt;
      vld_r <= vld_nxt; out_valid <= ov_nxt; fired_r <= fired_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      kind_r <= in_kind; now_r <= in_now; ival_r <= in_interval;
      tid_r <= in_timer_id; delta_r <= in_new_time - in_now;
    end
    rd_r <= rd_nxt; wr_r <= wr_nxt; cur_r <= cur_nxt; pend_id_r <= pend_id_nxt;
    drop_r <= drop_nxt;
    out_status <= os_nxt; out_result_id <= oid_nxt; out_deadline <= odl_nxt;
    out_occupancy <= 5'(occ_nxt); out_last <= ol_nxt;
  end
endmodule
`default_nettype wire

[verif/software_timer_table_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module software_timer_table_checker
  import stt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [47:0] in_now,
  input  wire logic [31:0] in_interval,
  input  wire logic        in_repeat_req,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [47:0] in_new_time,
  input  wire logic        out_valid,
  input  wire logic [2:0]  out_status,
  input  wire logic [31:0] out_result_id,
  input  wire logic [47:0] out_deadline,
  input  wire logic [4:0]  out_occupancy,
  input  wire logic        out_last,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [47:0] deadline;
    logic [4:0]  occupancy;
    logic        last;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic [31:0] tmr_id[TableDepth];
  logic [47:0] tmr_due[TableDepth];
  logic [31:0] tmr_period[TableDepth];
  logic        tmr_periodic[TableDepth];
  logic        tmr_marked[TableDepth];
  int          tmr_count;
  logic [31:0] id_seq;

  assign pending = expected_results.size();

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int find_timer(input logic [31:0] id);
    for (int i = 0; i < tmr_count; i++)
      if (tmr_id[i] == id) return i;
    return -1;
  endfunction

  task automatic move_timer(input int dst, input int src);
    tmr_id[dst]       = tmr_id[src];
    tmr_due[dst]      = tmr_due[src];
    tmr_period[dst]   = tmr_period[src];
    tmr_periodic[dst] = tmr_periodic[src];
    tmr_marked[dst]   = tmr_marked[src];
  endtask

  // works out every result of one accepted item and updates the table copy
  task automatic apply_timer_cmd(input logic [2:0] kind, input logic [47:0] now,
                                 input logic [31:0] ival, input logic rep,
                                 input logic [31:0] tid, input logic [47:0] ntime);
    timer_result_t res[$];
    timer_result_t r;
    int w;
    int s;
    logic keep;
    logic [47:0] delta;
    r = '0;
    case (kind)
      KIND_TICK: begin
        w = 0;
        for (int i = 0; i < tmr_count; i++)
          if (!tmr_marked[i]) begin
            if (w != i) move_timer(w, i);
            w++;
          end
        tmr_count = w;
        w = 0;
        for (int i = 0; i < tmr_count; i++) begin
          keep = 1'b1;
          if (tmr_due[i] <= now) begin
            r = '0;
            r.status = ST_OK;
            r.result_id = tmr_id[i];
            res = {res, r};
            if (!tmr_periodic[i]) keep = 1'b0;
            else if (tmr_period[i] == 0) tmr_due[i] = now;
            else tmr_due[i] = tmr_due[i] + {16'd0, tmr_period[i]};
          end
          if (keep) begin
            if (w != i) move_timer(w, i);
            w++;
          end
        end
        tmr_count = w;
        if (res.size() == 0) begin
          r = '0;
          r.status = ST_NONE_DUE;
          res = {res, r};
        end
      end
      KIND_SET: begin
        if (tmr_count >= TableDepth) r.status = ST_FULL;
        else begin
          id_seq = id_seq + 1;
          if (id_seq == 0) id_seq = 1;
          tmr_id[tmr_count]       = id_seq;
          tmr_due[tmr_count]      = now + {16'd0, ival};
          tmr_period[tmr_count]   = ival;
          tmr_periodic[tmr_count] = rep;
          tmr_marked[tmr_count]   = 1'b0;
          tmr_count++;
          r.status = ST_OK;
          r.result_id = id_seq;
        end
        res = {res, r};
      end
      KIND_CLEAR: begin
        if (tid[31]) r.status = ST_INVALID;
        else begin
          s = find_timer(tid);
          if (s < 0) r.status = ST_NOT_FOUND;
          else begin
            tmr_marked[s] = 1'b1;
            r.status = ST_OK;
          end
        end
        res = {res, r};
      end
      KIND_RESET: begin
        s = find_timer(tid);
        if (s < 0) r.status = ST_NOT_FOUND;
        else begin
          tmr_due[s] = now + {16'd0, ival};
          r.status = ST_OK;
        end
        res = {res, r};
      end
      KIND_PEEK: begin
        s = find_timer(tid);
        if (s < 0) r.status = ST_NOT_FOUND;
        else begin
          r.status = ST_OK;
          r.deadline = tmr_due[s];
        end
        res = {res, r};
      end
      KIND_SHIFT: begin
        delta = ntime - now;
        for (int i = 0; i < tmr_count; i++) tmr_due[i] = tmr_due[i] + delta;
        r.status = ST_OK;
        res = {res, r};
      end
      default: begin
        r.status = ST_OK;
        res = {res, r};
      end
    endcase
    foreach (res[k]) begin
      res[k].occupancy = tmr_count[4:0];
      res[k].last = (k == res.size() - 1);
      expected_results = {expected_results, res[k]};
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      tmr_count = 0;
      id_seq = '0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0)
          report_mismatch("result with nothing expected");
        else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", out_status, want.status));
          if (out_result_id !== want.result_id)
            report_mismatch($sformatf("result_id %0h want %0h", out_result_id,
                                      want.result_id));
          if (out_deadline !== want.deadline)
            report_mismatch($sformatf("deadline %0h want %0h", out_deadline,
                                      want.deadline));
          if (out_occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d want %0d", out_occupancy,
                                      want.occupancy));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b want %0b", out_last, want.last));
        end
      end
      if (start && !busy)
        apply_timer_cmd(in_kind, in_now, in_interval, in_repeat_req, in_timer_id,
                        in_new_time);
    end
  end

endmodule
`default_nettype wire

[verif/software_timer_table_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module software_timer_table_test;
  import stt_pkg::*;

  localparam int RandomItems = 320;
  localparam int StallLimit = 2000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [47:0] in_now;
  logic [31:0] in_interval;
  logic        in_repeat_req;
  logic [31:0] in_timer_id;
  logic [47:0] in_new_time;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_result_id;
  logic [47:0] out_deadline;
  logic [4:0]  out_occupancy;
  logic        out_last;
  int          fail_count;
  int          pending;

  // running clock of the stimulus and a rough count of handed-out ids
  logic [47:0] wall_ms;
  int          ids_given;
  logic        idle_on;
  int          quiet_cycles;

  software_timer_table dut (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_now, .in_interval, .in_repeat_req, .in_timer_id, .in_new_time,
    .out_valid, .out_status, .out_result_id, .out_deadline, .out_occupancy, .out_last
  );

  software_timer_table_checker checker_i (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_now, .in_interval, .in_repeat_req, .in_timer_id, .in_new_time,
    .out_valid, .out_status, .out_result_id, .out_deadline, .out_occupancy, .out_last,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: any cycle without an accepted item or a result counts
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("software_timer_table_test NOT OK");
      $finish;
    end
  end

  // presents one item and holds it until the block takes it
  task automatic send_cmd(input logic [2:0] kind, input logic [47:0] now,
                          input logic [31:0] ival, input logic rep,
                          input logic [31:0] tid, input logic [47:0] ntime);
    while (idle_on && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_kind       <= kind;
    in_now        <= now;
    in_interval   <= ival;
    in_repeat_req <= rep;
    in_timer_id   <= tid;
    in_new_time   <= ntime;
    if (kind == KIND_SET) ids_given++;
    do @(posedge clk); while (busy);
  endtask

  // ids near the recent end of the handed-out range, with some noise
  function automatic logic [31:0] pick_id();
    int lo;
    lo = (ids_given > 20) ? ids_given - 20 : 1;
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'd0;
      default: return $urandom_range(ids_given + 1, lo);
    endcase
  endfunction

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hffff_ffff;
      default: return $urandom_range(300);
    endcase
  endfunction

  task automatic random_item();
    logic [2:0]  kind;
    logic [47:0] now;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 33) kind = KIND_SET;
    else if (pick < 58) kind = KIND_TICK;
    else if (pick < 68) kind = KIND_CLEAR;
    else if (pick < 78) kind = KIND_RESET;
    else if (pick < 88) kind = KIND_PEEK;
    else if (pick < 95) kind = KIND_SHIFT;
    else kind = 3'($urandom_range(7, 6));
    // time mostly moves forward; now and then it jumps anywhere
    if ($urandom_range(19) == 0) now = 48'({$urandom(), $urandom()});
    else begin
      wall_ms = wall_ms + $urandom_range(120);
      now = wall_ms;
    end
    // bursts of sets drive the table to full
    if (kind == KIND_SET && $urandom_range(9) == 0)
      repeat ($urandom_range(18, 6))
        send_cmd(KIND_SET, wall_ms, pick_interval(), 1'($urandom()), $urandom(),
                 48'($urandom()));
    send_cmd(kind, now, pick_interval(), 1'($urandom()), pick_id(),
             ($urandom_range(3) == 0) ? 48'({$urandom(), $urandom()})
                                      : wall_ms + $urandom_range(500));
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_kind       <= KIND_TICK;
    in_now        <= '0;
    in_interval   <= '0;
    in_repeat_req <= 1'b0;
    in_timer_id   <= '0;
    in_new_time   <= '0;
    wall_ms = 48'd1000;
    ids_given = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, each operation and the odd cases
    send_cmd(KIND_TICK, 48'd0, 32'd0, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_PEEK, 48'd0, 32'd0, 1'b0, 32'd1, 48'd0);
    send_cmd(KIND_SET, 48'd100, 32'd0, 1'b1, 32'd0, 48'd0);
    send_cmd(KIND_SET, 48'd100, 32'hffff_ffff, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_SET, 48'hffff_ffff_fff0, 32'd50, 1'b1, 32'd0, 48'd0);
    send_cmd(KIND_SET, 48'd100, 32'd10, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_PEEK, 48'd0, 32'd0, 1'b0, 32'd3, 48'd0);
    send_cmd(KIND_CLEAR, 48'd0, 32'd0, 1'b0, 32'h8000_0000, 48'd0);
    send_cmd(KIND_CLEAR, 48'd0, 32'd0, 1'b0, 32'hffff_ffff, 48'd0);
    send_cmd(KIND_CLEAR, 48'd0, 32'd0, 1'b0, 32'h7fff_ffff, 48'd0);
    send_cmd(KIND_CLEAR, 48'd0, 32'd0, 1'b0, 32'd2, 48'd0);
    // a marked timer is still found until the next tick
    send_cmd(KIND_PEEK, 48'd0, 32'd0, 1'b0, 32'd2, 48'd0);
    send_cmd(KIND_RESET, 48'd200, 32'd5, 1'b0, 32'd2, 48'd0);
    send_cmd(KIND_RESET, 48'd200, 32'd5, 1'b0, 32'd99, 48'd0);
    send_cmd(KIND_TICK, 48'd110, 32'd0, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_TICK, 48'd110, 32'd0, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_SHIFT, 48'd500, 32'd0, 1'b0, 32'd0, 48'd100);
    send_cmd(KIND_SHIFT, 48'd0, 32'd0, 1'b0, 32'd0, 48'hffff_ffff_ffff);
    send_cmd(3'd6, 48'hffff_ffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff,
             48'hffff_ffff_ffff);
    send_cmd(3'd7, 48'd0, 32'd0, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_TICK, 48'hffff_ffff_ffff, 32'd0, 1'b0, 32'd0, 48'd0);
    send_cmd(KIND_PEEK, 48'd0, 32'd0, 1'b0, 32'd1, 48'd0);

    for (int n = 0; n < RandomItems; n++) begin
      idle_on = !(n >= 100 && n < 180);
      random_item();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("software_timer_table_test OK");
    else $display("software_timer_table_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hdl/stt_pkg.sv
hdl/stt_slot_ram.sv
hdl/software_timer_table.sv
verif/software_timer_table_checker.sv
verif/software_timer_table_test.sv
